>>> hdl/bma_pkg.sv
// Shared types and constants for the boxcar moving average block.
`timescale 1ns / 1ps
`default_nettype none
package bma_pkg;

	localparam int DEPTH_SHIFT_DEF  = 8;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int DATA_W           = 16;

	typedef enum logic {
		CMD_PUSH,
		CMD_PRELOAD
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_FILL
	} bma_state_t;

endpackage
`default_nettype wire

>>> hdl/bma_front.sv
// Input side: accepts transactions, classifies them and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module bma_front
	import bma_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    hold,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    in_op,
	input  wire logic [DATA_W-1:0]       in_sample,
	output logic                         q_valid,
	input  wire logic                    q_ready,
	output cmd_kind_t                    q_kind,
	output logic [SAMPLE_WIDTH-1:0]      q_sample
);

	logic [SAMPLE_WIDTH+DATA_W-1:0] smp_ext;
	logic [SAMPLE_WIDTH-1:0]        smp_masked;
	cmd_kind_t                      kind_in;
	cmd_kind_t                      kind_q [2];
	logic [SAMPLE_WIDTH-1:0]        smp_q [2];
	logic                           wr_q;
	logic                           rd_q;
	logic [1:0]                     cnt_q;
	logic                           push;
	logic                           pop;

	assign smp_ext    = {{SAMPLE_WIDTH{1'b0}}, in_sample};
	assign smp_masked = smp_ext[SAMPLE_WIDTH-1:0];
	assign kind_in    = in_op ? CMD_PRELOAD : CMD_PUSH;

	assign in_ready = (cnt_q != 2'd2) && !hold;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_kind   = kind_q[rd_q];
	assign q_sample = smp_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_q] <= kind_in;
			smp_q[wr_q]  <= smp_masked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/bma_back.sv
// Engine: window ring, running total, fill sweeps and the result buffer.
`timescale 1ns / 1ps
`default_nettype none
module bma_back
	import bma_pkg::*;
#(
	parameter int DEPTH_SHIFT  = DEPTH_SHIFT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	output logic                         clearing,
	input  wire logic                    q_valid,
	output logic                         q_ready,
	input  wire cmd_kind_t               q_kind,
	input  wire logic [SAMPLE_WIDTH-1:0] q_sample,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [DATA_W-1:0]            out_average
);

	localparam int DEPTH   = 1 << DEPTH_SHIFT;
	localparam int TOTAL_W = SAMPLE_WIDTH + DEPTH_SHIFT;

	logic [SAMPLE_WIDTH-1:0] ring [DEPTH];

	bma_state_t               state_q;
	bma_state_t               state_d;
	logic [DEPTH_SHIFT-1:0]   cnt_q;
	logic [DEPTH_SHIFT-1:0]   ptr_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [SAMPLE_WIDTH-1:0]  fill_q;

	logic                     valid_s1;
	logic [DEPTH_SHIFT-1:0]   addr_s1;
	logic [SAMPLE_WIDTH-1:0]  smp_s1;
	logic [SAMPLE_WIDTH-1:0]  rd_data_s1;

	logic [DATA_W-1:0]        obuf_q [2];
	logic                     owr_q;
	logic                     ord_q;
	logic [1:0]               ocnt_q;

	logic                     pop;
	logic                     pop_push;
	logic                     pop_preload;
	logic                     credit_ok;
	logic [2:0]               occupancy;
	logic                     out_pop;
	logic                     out_push;
	logic [DATA_W-1:0]        out_data;
	logic [TOTAL_W-1:0]       total_new;
	logic [TOTAL_W+DATA_W-1:0] total_wide;
	logic [SAMPLE_WIDTH+DATA_W-1:0] fill_wide;
	logic                     wr_en;
	logic [DEPTH_SHIFT-1:0]   wr_addr;
	logic [SAMPLE_WIDTH-1:0]  wr_data;
	logic                     sweep_last;

	assign clearing   = (state_q == ST_CLEAR);
	assign out_valid  = (ocnt_q != 2'd0);
	assign out_pop    = out_valid && out_ready;
	assign out_average = obuf_q[ord_q];
	assign sweep_last = (cnt_q == {DEPTH_SHIFT{1'b1}});

	assign occupancy = {1'b0, ocnt_q} + {2'b00, valid_s1} - {2'b00, out_pop};
	assign credit_ok = (occupancy < 3'd2);

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (sweep_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				q_ready = credit_ok && ((q_kind == CMD_PUSH) || !valid_s1);
				if (q_valid && q_ready && (q_kind == CMD_PRELOAD)) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sweep_last) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign pop         = q_valid && q_ready;
	assign pop_push    = pop && (q_kind == CMD_PUSH);
	assign pop_preload = pop && (q_kind == CMD_PRELOAD);

	assign total_new  = total_q - {{DEPTH_SHIFT{1'b0}}, rd_data_s1}
		+ {{DEPTH_SHIFT{1'b0}}, smp_s1};
	assign total_wide = {{DATA_W{1'b0}}, total_new} >> DEPTH_SHIFT;
	assign fill_wide  = {{DATA_W{1'b0}}, q_sample};

	assign out_push = valid_s1 || pop_preload;
	assign out_data = valid_s1 ? total_wide[DATA_W-1:0] : fill_wide[DATA_W-1:0];

	assign wr_en   = valid_s1 || (state_q != ST_RUN);
	assign wr_addr = valid_s1 ? addr_s1 : cnt_q;
	assign wr_data = valid_s1 ? smp_s1
		: ((state_q == ST_CLEAR) ? {SAMPLE_WIDTH{1'b0}} : fill_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring[wr_addr] <= wr_data;
		end
		rd_data_s1 <= ring[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (pop_push) begin
			addr_s1 <= ptr_q;
			smp_s1  <= q_sample;
		end
		if (pop_preload) begin
			fill_q <= q_sample;
		end
		if (out_push) begin
			obuf_q[owr_q] <= out_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cnt_q    <= '0;
			ptr_q    <= '0;
			total_q  <= '0;
			valid_s1 <= 1'b0;
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			ocnt_q   <= 2'd0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= pop_push;
			if (state_q != ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop_push) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (pop_preload) begin
				ptr_q <= '0;
			end
			if (pop_preload) begin
				total_q <= {q_sample, {DEPTH_SHIFT{1'b0}}};
			end else if (valid_s1) begin
				total_q <= total_new;
			end
			if (out_push) begin
				owr_q <= ~owr_q;
			end
			if (out_pop) begin
				ord_q <= ~ord_q;
			end
			unique case ({out_push, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/boxcar_moving_average.sv
// Top level of the boxcar moving average filter.
// The block returns the truncated mean of the last 2^DEPTH_SHIFT samples.
// Input transactions arrive on s_axis: tdata carries the sample and tuser
// carries the operation (0 pushes a sample, 1 preloads the whole window).
// Each input transaction yields exactly one result on m_axis, in order.
// A push result passes the input queue, the engine stage and the result buffer.
// Pushes sustain one transaction per cycle while m_axis_tready stays high and
// no preload or clear runs; each sample takes one read-modify-write of the ring.
// A preload answers its sample and then occupies the ring write port while it
// fills every entry; later items wait in the input queue meanwhile.
// After reset the ring is cleared to zero in a pass over every entry, during
// which s_axis_tready stays low.
// When the receiver holds m_axis_tready low, results collect in a two-entry
// buffer, then inputs in a two-entry input queue, and s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module boxcar_moving_average
	import bma_pkg::*;
#(
	parameter int DEPTH_SHIFT  = DEPTH_SHIFT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [DATA_W-1:0] s_axis_tdata,   // [15:0] sample
	input  wire logic [0:0]        s_axis_tuser,   // [0] op
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata    // [15:0] average
);

	logic                    clearing;
	logic                    q_valid;
	logic                    q_ready;
	cmd_kind_t               q_kind;
	logic [SAMPLE_WIDTH-1:0] q_sample;

	bma_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (clearing),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser[0]),
		.in_sample(s_axis_tdata),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_kind   (q_kind),
		.q_sample (q_sample)
	);

	bma_back #(
		.DEPTH_SHIFT (DEPTH_SHIFT),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_kind     (q_kind),
		.q_sample   (q_sample),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_average(m_axis_tdata)
	);

endmodule
`default_nettype wire
